[rtl/iptp_pkg.sv]
`timescale 1ns / 1ps

package iptp_pkg;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_V4,
        PH_V6_LEAD,
        PH_V6,
        PH_V6_TAIL,
        PH_BAD,
        PH_UNSUP
    } phase_t;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED   = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    localparam logic [1:0] FAMILY_V4 = 2'd0;
    localparam logic [1:0] FAMILY_V6 = 2'd1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;

    // byte i of the address is element i
    typedef logic [15:0][7:0] addr_bytes_t;

    typedef struct packed {
        addr_bytes_t bytes;
        logic [4:0]  write_pos;
        logic [4:0]  gap_pos;
        logic        gap_seen;
    } finish_req_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] high;
        logic [63:0] low;
    } finish_rsp_t;

    typedef struct packed {
        logic       valid;
        logic       decimal;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.valid   = 1'b1;
            h.decimal = 1'b1;
            h.value   = c[3:0];
        end
        // 'a'-'f' and 'A'-'F' share the low nibble 1..6
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.valid = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

[rtl/iptp_if.sv]
`timescale 1ns / 1ps

interface iptp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic [1:0] family;

    modport source (output valid, output text_char, output family, input ready);
    modport sink (input valid, input text_char, input family, output ready);
endinterface

interface iptp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, output status, output address_high, output address_low,
                    input ready);
    modport sink (input valid, input status, input address_high, input address_low,
                  output ready);
endinterface

[rtl/iptp_finish.sv]
`timescale 1ns / 1ps

// closes an ipv6 string: moves the bytes after the gap to the end, checks the length
module iptp_finish (
    input  iptp_pkg::finish_req_t req,
    output iptp_pkg::finish_rsp_t rsp
);

    iptp_pkg::addr_bytes_t moved;
    logic [4:0]            tail_len;
    logic [4:0]            tail_start;
    logic [4:0]            src_idx;
    logic                  ok;
    logic [63:0]           high;
    logic [63:0]           low;

    always_comb
    begin
        tail_len   = req.write_pos - req.gap_pos;
        tail_start = 5'd16 - tail_len;
        src_idx    = '0;
        moved      = req.bytes;
        if (req.gap_seen)
        begin
            for (int j = 0; j < 16; j++)
            begin
                // source byte is j - 16 + write_pos, taken mod 16
                src_idx = 5'(j) + req.write_pos;
                if (5'(j) < req.gap_pos)
                    moved[j] = req.bytes[j];
                else if (5'(j) >= tail_start)
                    moved[j] = req.bytes[src_idx[3:0]];
                else
                    moved[j] = 8'h00;
            end
        end

        if (req.gap_seen)
            ok = (req.write_pos < 5'd16) && (req.gap_pos <= req.write_pos);
        else
            ok = (req.write_pos == 5'd16);

        high = '0;
        low  = '0;
        for (int j = 0; j < 8; j++)
        begin
            high = {high[55:0], moved[j]};
            low  = {low[55:0], moved[j + 8]};
        end

        rsp.ok   = ok;
        rsp.high = ok ? high : 64'd0;
        rsp.low  = ok ? low : 64'd0;
    end

endmodule

[rtl/ip_address_text_parser.sv]
`timescale 1ns / 1ps
// a NUL beat passes the input register, then the result register, before its result is valid
// throughput: one character beat per cycle; a NUL beat waits only while the
//   result register holds an untaken result
// characters other than NUL give no result; one result per string
// reset (rst_n low, async) empties both registers and waits for a string start
module ip_address_text_parser (
    input  logic              clk,
    input  logic              rst_n,
    iptp_in_if.sink           text,
    iptp_out_if.source        result
);

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic [1:0]  s1_family_reg;

    // parse state
    iptp_pkg::phase_t      phase_reg, phase_next;
    iptp_pkg::addr_bytes_t bytes_reg, bytes_next;
    logic [4:0]            wp_reg, wp_next;
    logic [4:0]            gap_pos_reg, gap_pos_next;
    logic                  gap_seen_reg, gap_seen_next;
    logic [15:0]           gv_reg, gv_next;
    logic                  ghd_reg, ghd_next;
    logic [7:0]            ov_reg, ov_next;
    logic                  tok_reg, tok_next;
    logic [2:0]            oc_reg, oc_next;
    logic                  lwgc_reg, lwgc_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg, out_status_next;
    logic [63:0] out_high_reg, out_high_next;
    logic [63:0] out_low_reg, out_low_next;

    logic proc;
    logic emit;
    logic fin_emit;
    logic [1:0]  emit_status;
    logic [63:0] emit_low;

    iptp_pkg::finish_req_t fin_req;
    iptp_pkg::finish_rsp_t fin_rsp;

    // string-start view of the state
    iptp_pkg::phase_t      e_phase;
    iptp_pkg::phase_t      step_phase;
    iptp_pkg::addr_bytes_t e_bytes;
    iptp_pkg::addr_bytes_t grp_bytes;
    logic [4:0]            e_wp;
    logic [4:0]            e_gap_pos;
    logic                  e_gap_seen;
    logic [15:0]           e_gv;
    logic                  e_ghd;
    logic [7:0]            e_ov;
    logic                  e_tok;
    logic [2:0]            e_oc;
    logic                  e_lwgc;
    logic                  start_lead;
    logic [7:0]            c;
    logic                  is_digit;
    iptp_pkg::hex_t        hx;
    logic [11:0]           dec_sum;
    logic [2:0]            oc_inc;
    logic [3:0]            tail_idx;
    logic [3:0]            wp_lo;

    // a NUL beat needs room in the result register
    assign proc = s1_valid_reg &&
                  (s1_char_reg != iptp_pkg::CHAR_NUL || !out_valid_reg || result.ready);
    assign text.ready = !s1_valid_reg || proc;

    assign s1_valid_next = text.valid ? 1'b1 : (proc ? 1'b0 : s1_valid_reg);

    always_comb
    begin
        c        = s1_char_reg;
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        hx       = iptp_pkg::hex_decode(c);

        e_phase    = phase_reg;
        e_bytes    = bytes_reg;
        e_wp       = wp_reg;
        e_gap_pos  = gap_pos_reg;
        e_gap_seen = gap_seen_reg;
        e_gv       = gv_reg;
        e_ghd      = ghd_reg;
        e_ov       = ov_reg;
        e_tok      = tok_reg;
        e_oc       = oc_reg;
        e_lwgc     = lwgc_reg;
        start_lead = 1'b0;

        if (phase_reg == iptp_pkg::PH_AWAIT)
        begin
            e_bytes    = '0;
            e_wp       = '0;
            e_gap_pos  = '0;
            e_gap_seen = 1'b0;
            e_gv       = '0;
            e_ghd      = 1'b0;
            e_ov       = '0;
            e_tok      = 1'b1;
            e_oc       = '0;
            e_lwgc     = 1'b0;
            case (s1_family_reg)
                iptp_pkg::FAMILY_V4:
                    e_phase = iptp_pkg::PH_V4;
                iptp_pkg::FAMILY_V6:
                begin
                    if (c == iptp_pkg::CHAR_COLON)
                    begin
                        e_phase    = iptp_pkg::PH_V6_LEAD;
                        start_lead = 1'b1;
                    end
                    else
                        e_phase = iptp_pkg::PH_V6;
                end
                default:
                    e_phase = iptp_pkg::PH_UNSUP;
            endcase
        end

        // second colon of a leading gap is handled as an ordinary v6 colon
        step_phase = e_phase;
        if (e_phase == iptp_pkg::PH_V6_LEAD && !start_lead && c == iptp_pkg::CHAR_COLON)
            step_phase = iptp_pkg::PH_V6;

        dec_sum  = {4'd0, e_ov} * 12'd10 + {8'd0, c[3:0]};
        oc_inc   = e_ghd ? e_oc : e_oc + 3'd1;
        wp_lo    = e_wp[3:0];
        tail_idx = wp_lo + {1'b0, oc_inc} - 4'd1;

        grp_bytes                = e_bytes;
        grp_bytes[wp_lo]         = e_gv[15:8];
        grp_bytes[wp_lo + 4'd1]  = e_gv[7:0];

        phase_next    = step_phase;
        bytes_next    = e_bytes;
        wp_next       = e_wp;
        gap_pos_next  = e_gap_pos;
        gap_seen_next = e_gap_seen;
        gv_next       = e_gv;
        ghd_next      = e_ghd;
        ov_next       = e_ov;
        tok_next      = e_tok;
        oc_next       = e_oc;
        lwgc_next     = e_lwgc;

        emit        = 1'b0;
        fin_emit    = 1'b0;
        emit_status = iptp_pkg::STATUS_MALFORMED;
        emit_low    = '0;
        fin_req     = '{bytes: e_bytes, write_pos: e_wp, gap_pos: e_gap_pos,
                        gap_seen: e_gap_seen};

        case (step_phase)
            iptp_pkg::PH_V4:
            begin
                if (c == iptp_pkg::CHAR_NUL)
                begin
                    emit = 1'b1;
                    if (e_oc >= 3'd4)
                    begin
                        emit_status = iptp_pkg::STATUS_OK;
                        emit_low    = {32'd0, e_bytes[0], e_bytes[1], e_bytes[2], e_bytes[3]};
                    end
                end
                else if (is_digit)
                begin
                    if (dec_sum > 12'd255 || oc_inc > 3'd4)
                        phase_next = iptp_pkg::PH_BAD;
                    else
                    begin
                        ov_next                     = dec_sum[7:0];
                        bytes_next[{2'b00, e_wp[1:0]}] = dec_sum[7:0];
                        oc_next                     = oc_inc;
                        ghd_next                    = 1'b1;
                    end
                end
                else if (c == iptp_pkg::CHAR_DOT && e_ghd && e_oc < 3'd4)
                begin
                    wp_next  = {3'd0, e_wp[1:0] + 2'd1};
                    ov_next  = '0;
                    ghd_next = 1'b0;
                end
                else
                    phase_next = iptp_pkg::PH_BAD;
            end

            iptp_pkg::PH_V6_LEAD:
            begin
                if (start_lead)
                    phase_next = iptp_pkg::PH_V6_LEAD;
                else if (c == iptp_pkg::CHAR_NUL)
                    emit = 1'b1;
                else
                    phase_next = iptp_pkg::PH_BAD;
            end

            iptp_pkg::PH_V6:
            begin
                lwgc_next = 1'b0;
                if (c == iptp_pkg::CHAR_NUL)
                begin
                    if (e_lwgc)
                        emit = 1'b1;
                    else if (e_ghd)
                    begin
                        if (e_wp > 5'd14)
                            emit = 1'b1;
                        else
                        begin
                            fin_emit          = 1'b1;
                            fin_req.bytes     = grp_bytes;
                            fin_req.write_pos = e_wp + 5'd2;
                        end
                    end
                    else
                        fin_emit = 1'b1;
                end
                else if (hx.valid)
                begin
                    if (e_gv[15:12] != 4'd0)
                        phase_next = iptp_pkg::PH_BAD;
                    else
                    begin
                        gv_next  = {e_gv[11:0], hx.value};
                        ghd_next = 1'b1;
                        if (!hx.decimal)
                            tok_next = 1'b0;
                        else if (e_tok)
                        begin
                            if (dec_sum > 12'd255)
                                tok_next = 1'b0;
                            else
                                ov_next = dec_sum[7:0];
                        end
                    end
                end
                else if (c == iptp_pkg::CHAR_COLON)
                begin
                    tok_next = 1'b1;
                    ov_next  = '0;
                    if (!e_ghd)
                    begin
                        if (e_gap_seen)
                            phase_next = iptp_pkg::PH_BAD;
                        else
                        begin
                            gap_seen_next = 1'b1;
                            gap_pos_next  = e_wp;
                        end
                    end
                    else if (e_wp > 5'd14)
                        phase_next = iptp_pkg::PH_BAD;
                    else
                    begin
                        bytes_next = grp_bytes;
                        wp_next    = e_wp + 5'd2;
                        ghd_next   = 1'b0;
                        gv_next    = '0;
                        lwgc_next  = 1'b1;
                    end
                end
                else if (c == iptp_pkg::CHAR_DOT && e_ghd && e_tok && e_wp <= 5'd12)
                begin
                    // the token so far becomes the first octet of a dotted tail
                    bytes_next[wp_lo] = e_ov;
                    oc_next           = 3'd1;
                    ov_next           = '0;
                    ghd_next          = 1'b0;
                    phase_next        = iptp_pkg::PH_V6_TAIL;
                end
                else
                    phase_next = iptp_pkg::PH_BAD;
            end

            iptp_pkg::PH_V6_TAIL:
            begin
                if (c == iptp_pkg::CHAR_NUL)
                begin
                    if (e_oc < 3'd4)
                        emit = 1'b1;
                    else
                    begin
                        fin_emit          = 1'b1;
                        fin_req.write_pos = e_wp + 5'd4;
                    end
                end
                else if (is_digit)
                begin
                    if (dec_sum > 12'd255 || oc_inc > 3'd4)
                        phase_next = iptp_pkg::PH_BAD;
                    else
                    begin
                        ov_next              = dec_sum[7:0];
                        oc_next              = oc_inc;
                        ghd_next             = 1'b1;
                        bytes_next[tail_idx] = dec_sum[7:0];
                    end
                end
                else if (c == iptp_pkg::CHAR_DOT && e_ghd && e_oc < 3'd4)
                begin
                    ov_next  = '0;
                    ghd_next = 1'b0;
                end
                else
                    phase_next = iptp_pkg::PH_BAD;
            end

            iptp_pkg::PH_UNSUP:
            begin
                if (c == iptp_pkg::CHAR_NUL)
                begin
                    emit        = 1'b1;
                    emit_status = iptp_pkg::STATUS_UNSUPPORTED;
                end
            end

            default:
            begin
                if (c == iptp_pkg::CHAR_NUL)
                    emit = 1'b1;
                else
                    phase_next = iptp_pkg::PH_BAD;
            end
        endcase

        if (emit || fin_emit)
            phase_next = iptp_pkg::PH_AWAIT;
    end

    iptp_finish u_finish (
        .req (fin_req),
        .rsp (fin_rsp)
    );

    always_comb
    begin
        if (fin_emit)
        begin
            out_status_next = fin_rsp.ok ? iptp_pkg::STATUS_OK : iptp_pkg::STATUS_MALFORMED;
            out_high_next   = fin_rsp.high;
            out_low_next    = fin_rsp.low;
        end
        else
        begin
            out_status_next = emit_status;
            out_high_next   = '0;
            out_low_next    = emit_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= iptp_pkg::PH_AWAIT;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (proc)
                phase_reg <= phase_next;
            if (proc && (emit || fin_emit))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_char_reg   <= text.text_char;
            s1_family_reg <= text.family;
        end
        if (proc)
        begin
            bytes_reg    <= bytes_next;
            wp_reg       <= wp_next;
            gap_pos_reg  <= gap_pos_next;
            gap_seen_reg <= gap_seen_next;
            gv_reg       <= gv_next;
            ghd_reg      <= ghd_next;
            ov_reg       <= ov_next;
            tok_reg      <= tok_next;
            oc_reg       <= oc_next;
            lwgc_reg     <= lwgc_next;
        end
        if (proc && (emit || fin_emit))
        begin
            out_status_reg <= out_status_next;
            out_high_reg   <= out_high_next;
            out_low_reg    <= out_low_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.address_high = out_high_reg;
    assign result.address_low  = out_low_reg;

endmodule

[rtl/iptp_checker.sv]
`timescale 1ns / 1ps

module iptp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        text_valid,
    input logic        text_ready,
    input logic [7:0]  text_char,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  status,
    input logic [63:0] address_high,
    input logic [63:0] address_low
);

    // a stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(address_high) && $stable(address_low))
    else $error("result beat changed while stalled");

    // a failed parse carries an all-zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != iptp_pkg::STATUS_OK |->
            address_high == 64'd0 && address_low == 64'd0)
    else $error("nonzero address with error status");

    // a fresh result follows an accepted NUL beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |->
            $past(text_valid && text_ready && text_char == iptp_pkg::CHAR_NUL, 2))
    else $error("result without a preceding NUL beat");

    // input back-pressure only comes from a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> result_valid && !result_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind ip_address_text_parser iptp_checker u_iptp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text.valid),
    .text_ready   (text.ready),
    .text_char    (text.text_char),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (result.status),
    .address_high (result.address_high),
    .address_low  (result.address_low)
);
